// ===== sv/pocc_pkg.sv =====
// Shared field widths, codes and reset values of the pairwise overlap collision counter.
package pocc_pkg;

  // Field widths of one input item and one result item.
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 10;
  localparam int POS_W    = 16;
  localparam int IMPACT_W = 15;
  localparam int PART_W   = 12;
  localparam int COLL_W   = 21;

  // Configuration register widths and port layout.
  localparam int D0_W      = 32;
  localparam int COUNT_W   = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_D0_SQUARED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'd1;

  // Register reset values.
  localparam logic [D0_W-1:0]    D0_RESET    = 32'd155760;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd591;

endpackage

// ===== sv/pocc_item_if.sv =====
// Input channel: load and compute items with valid/ready handshake.
interface pocc_item_if;
  import pocc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic [SLOT_W-1:0]          slot;
  logic signed [POS_W-1:0]    x_pos;
  logic signed [POS_W-1:0]    y_pos;
  logic [IMPACT_W-1:0]        impact;

  modport source (output valid, kind, slot, x_pos, y_pos, impact, input ready);
  modport sink (input valid, kind, slot, x_pos, y_pos, impact, output ready);
endinterface

// ===== sv/pocc_result_if.sv =====
// Result channel: participant and collision counts with valid/ready handshake.
interface pocc_result_if;
  import pocc_pkg::*;

  logic              valid;
  logic              ready;
  logic [PART_W-1:0] participants;
  logic [COLL_W-1:0] collisions;

  modport source (output valid, participants, collisions, input ready);
  modport sink (input valid, participants, collisions, output ready);
endinterface

// ===== sv/pairwise_overlap_collision_counter.sv =====
// Top level: point stores, pair pipeline and sequencer of the collision counter.
//
//   channel   dir  handshake          payload
//   item      in   valid/ready        kind, slot, x_pos, y_pos, impact
//   result    out  valid/ready        participants, collisions
//   cfg       in   cfg_wr_en          cfg_index, cfg_data
//
// A compute item with n points in use walks all n*n A-B pairs: one pair enters the
// shared distance pipeline per cycle, then a sweep over the n B points counts the
// B nucleons that were hit.
// The single read port of each point store sets the pair rate.
// Reset is synchronous and needs no clearing pass; the item channel is not ready
// while a compute runs or while a finished result waits for a free output register.
module pairwise_overlap_collision_counter #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [pocc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pocc_pkg::CFG_W-1:0]     cfg_data,
  pocc_item_if.sink                      item,
  pocc_result_if.source                  result
);
  import pocc_pkg::*;

  // Index, count and difference widths.
  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  // Tag that travels with each pair through the pipeline.
  typedef struct packed {
    logic          valid;
    logic          first_row;
    logic          row_end;
    logic [IW-1:0] col;
  } pair_tag_t;

  state_t state;

  // Configuration registers.
  logic [D0_W-1:0]    d0_squared;
  logic [COUNT_W-1:0] point_count;

  // Sequencer registers.
  logic [IW-1:0]       row;
  logic [IW-1:0]       col;
  logic [CW-1:0]       n;
  logic [IMPACT_W-1:0] impact_q;
  logic [COLL_W-1:0]   pair_total;
  logic [PART_W-1:0]   hit_total;
  logic                row_any;
  logic                res_valid;
  logic [PART_W-1:0]   res_part;
  logic [COLL_W-1:0]   res_coll;

  // Point stores and the B-side hit flags.
  logic signed [COORD_BITS-1:0] a_x_mem [MAX_POINTS];
  logic signed [COORD_BITS-1:0] a_y_mem [MAX_POINTS];
  logic signed [COORD_BITS-1:0] b_x_mem [MAX_POINTS];
  logic signed [COORD_BITS-1:0] b_y_mem [MAX_POINTS];
  logic                         hit_mem [MAX_POINTS];

  // Pipeline registers.
  pair_tag_t tag1, tag2, tag3, tag4, tag5;
  logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic [15:0] mx_q, my_q;
  logic        big3, big4;
  logic [31:0] sqx_q, sqy_q;
  logic        hit5;
  logic        sweep_v;
  logic        flag_q;

  // Combinational helpers.
  logic          accept;
  logic          slot_ok;
  logic [IW-1:0] wr_addr;
  logic [CW-1:0] n_in;
  logic [CW-1:0] n_last;
  logic          col_last;
  logic          row_last;
  logic          pipe_busy;
  logic          res_load;
  pair_tag_t     issue_tag;
  logic signed [DW-1:0] dx_c, dy_c;
  logic [DW-1:0] mag_x, mag_y;
  logic [32:0]   d2;
  logic          hit_c;

  assign accept  = item.valid && item.ready;
  assign slot_ok = 32'(item.slot) < MAX_POINTS;
  assign wr_addr = IW'(item.slot);
  assign n_in    = (32'(point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);
  assign n_last  = n - CW'(1);
  assign col_last = CW'(col) == n_last;
  assign row_last = CW'(row) == n_last;
  assign pipe_busy = tag1.valid || tag2.valid || tag3.valid || tag4.valid || tag5.valid;
  assign res_load  = (state == ST_FINISH) && !sweep_v && (!res_valid || result.ready);

  assign item.ready          = (state == ST_IDLE);
  assign result.valid        = res_valid;
  assign result.participants = res_part;
  assign result.collisions   = res_coll;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      d0_squared  <= D0_RESET;
      point_count <= COUNT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_D0_SQUARED:  d0_squared  <= cfg_data[D0_W-1:0];
        REG_POINT_COUNT: point_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Nucleus A store: loaded by items, read at the current row.
  always_ff @(posedge clk) begin
    if (accept && item.kind == KIND_LOAD_A && slot_ok) begin
      a_x_mem[wr_addr] <= COORD_BITS'(item.x_pos);
      a_y_mem[wr_addr] <= COORD_BITS'(item.y_pos);
    end
    ax_q <= a_x_mem[row];
    ay_q <= a_y_mem[row];
  end

  // Nucleus B store: loaded by items, read at the current column.
  always_ff @(posedge clk) begin
    if (accept && item.kind == KIND_LOAD_B && slot_ok) begin
      b_x_mem[wr_addr] <= COORD_BITS'(item.x_pos);
      b_y_mem[wr_addr] <= COORD_BITS'(item.y_pos);
    end
    bx_q <= b_x_mem[col];
    by_q <= b_y_mem[col];
  end

  // Hit flags of B: the first row writes every flag, later rows only set them.
  always_ff @(posedge clk) begin
    if (tag5.valid && (tag5.first_row || hit5)) begin
      hit_mem[tag5.col] <= hit5;
    end
    flag_q <= hit_mem[col];
  end

  // Tag of the pair issued this cycle.
  always_comb begin
    issue_tag.valid     = (state == ST_RUN);
    issue_tag.first_row = (row == '0);
    issue_tag.row_end   = col_last;
    issue_tag.col       = col;
  end

  // Distance datapath: difference, magnitude, square, sum and compare.
  assign dx_c  = DW'(ax_q) - DW'(bx_q) + DW'($signed({1'b0, impact_q}));
  assign dy_c  = DW'(ay_q) - DW'(by_q);
  assign mag_x = dx_q[DW-1] ? ((~dx_q) + {{(DW-1){1'b0}}, 1'b1}) : dx_q;
  assign mag_y = dy_q[DW-1] ? ((~dy_q) + {{(DW-1){1'b0}}, 1'b1}) : dy_q;
  assign d2    = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign hit_c = !big4 && (d2 <= {1'b0, d0_squared});

  // Pipeline tags need reset; the data stages do not.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1    <= '0;
      tag2    <= '0;
      tag3    <= '0;
      tag4    <= '0;
      tag5    <= '0;
      sweep_v <= 1'b0;
    end else begin
      tag1    <= issue_tag;
      tag2    <= tag1;
      tag3    <= tag2;
      tag4    <= tag3;
      tag5    <= tag4;
      sweep_v <= (state == ST_SWEEP);
    end
  end

  always_ff @(posedge clk) begin
    dx_q  <= dx_c;
    dy_q  <= dy_c;
    // A magnitude of 2^16 or more squares past any 32-bit distance.
    mx_q  <= mag_x[15:0];
    my_q  <= mag_y[15:0];
    big3  <= (|mag_x[DW-1:16]) || (|mag_y[DW-1:16]);
    sqx_q <= mx_q * mx_q;
    sqy_q <= my_q * my_q;
    big4  <= big3;
    hit5  <= hit_c;
  end

  // Sequencer, counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      row        <= '0;
      col        <= '0;
      n          <= '0;
      impact_q   <= '0;
      pair_total <= '0;
      hit_total  <= '0;
      row_any    <= 1'b0;
      res_valid  <= 1'b0;
      res_part   <= '0;
      res_coll   <= '0;
    end else begin
      // Count pairs and A nucleons as results leave the pipeline.
      if (tag5.valid) begin
        if (hit5 && pair_total != '1) begin
          pair_total <= pair_total + 1'b1;
        end
        if (tag5.row_end) begin
          row_any <= 1'b0;
          if ((row_any || hit5) && hit_total != '1) begin
            hit_total <= hit_total + 1'b1;
          end
        end else begin
          row_any <= row_any || hit5;
        end
      end

      // Count B nucleons during the sweep.
      if (sweep_v && flag_q && hit_total != '1) begin
        hit_total <= hit_total + 1'b1;
      end

      // Load the finished counts into the result register, or free it once taken.
      if (res_load) begin
        res_valid <= 1'b1;
        res_part  <= hit_total;
        res_coll  <= pair_total;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept && item.kind == KIND_COMPUTE) begin
            impact_q   <= item.impact;
            n          <= n_in;
            row        <= '0;
            col        <= '0;
            pair_total <= '0;
            hit_total  <= '0;
            row_any    <= 1'b0;
            state      <= (n_in == '0) ? ST_FINISH : ST_RUN;
          end
        end
        ST_RUN: begin
          if (col_last) begin
            col <= '0;
            if (row_last) begin
              state <= ST_DRAIN;
            end else begin
              row <= row + 1'b1;
            end
          end else begin
            col <= col + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            col   <= '0;
            state <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (col_last) begin
            state <= ST_FINISH;
          end else begin
            col <= col + 1'b1;
          end
        end
        ST_FINISH: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Pairs leave the pipeline only while the pair walk or its drain is under way.
  a_pipe_in_compute: assert property (@(posedge clk) disable iff (rst)
    tag5.valid |-> (state == ST_RUN || state == ST_DRAIN))
    else $error("pair pipeline active outside the pair walk");

  // The sweep starts only after the pair pipeline is empty.
  a_sweep_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> !pipe_busy)
    else $error("hit sweep overlaps the pair pipeline");

  // Row and column stay inside the points in use during the walk.
  a_walk_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (CW'(row) < n && CW'(col) < n))
    else $error("pair walk index out of range");

  // A result appears only when the finish step loads it.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside the finish step");

  // No item is taken while the hit sweep still delivers flags.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> (!sweep_v && !tag1.valid))
    else $error("item channel ready while work is in flight");

endmodule
